>>> rtl/core/ser_pkg.sv
// Shared widths, codes and record type for the speed extremes recorder.
package ser_pkg;

  localparam int RECORDS_DEF   = 64;
  localparam int STEP_BITS_DEF = 24;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int SPD_W   = 12;
  localparam int TIME_W  = 12;
  localparam int DIST_W  = 35;
  localparam int SLOT_W  = 7;
  localparam int LAMP_W  = 8;
  localparam int MMPS_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [SPD_W-1:0]  MIN_RESET   = SPD_W'(990);
  localparam logic [SPD_W-1:0]  SPEED_SCALE = SPD_W'(10);
  localparam logic [MMPS_W-1:0] MMPS_RESET  = MMPS_W'(1725);

  localparam logic [OP_W-1:0] OP_SPEED   = 2'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
  localparam logic [OP_W-1:0] OP_READOUT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAMP_ID     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_STEP = 1'd1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_RECORD = 1'b1;

  typedef struct packed {
    logic [SPD_W-1:0]  max_spd;
    logic [SPD_W-1:0]  min_spd;
    logic [TIME_W-1:0] max_time;
    logic [TIME_W-1:0] min_time;
  } rec_t;

endpackage

>>> rtl/core/ser_rec_mem.sv
// Record store: one synchronous write port and one registered read port.
module ser_rec_mem
  import ser_pkg::*;
#(
  parameter int RECORDS = RECORDS_DEF,
  localparam int IDX_W = (RECORDS > 1) ? $clog2(RECORDS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [RECORDS];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/speed_extremes_recorder.sv
// Top level of the speed extremes recorder: frame processing, capture and readout.
//
// Every input beat is a speed frame, a capture request or a readout request. A speed
// frame is accepted, then the step counter and the running extremes are updated, then
// the step count times millimetres-per-step multiply is registered, and then the
// distance is saturated into the output register once that register is free; no new
// beat is taken before this result is loaded. Capture requests and unused opcodes give
// no result. A readout reads and then checks each slot up to the last nonempty one, as
// the record memory has a registered read port; empty slots are skipped and the last
// listed beat carries last. A pending capture (left by a nonzero speed) or a capture
// request is performed in the accepting cycle, before the item itself is processed.
// Slots are filled in order, so the fill count tells written slots from untouched ones
// and the record memory needs no clearing after reset. Results sit in an output
// register, so the next input beat can be taken while a result still waits on
// out_stall.
module speed_extremes_recorder
  import ser_pkg::*;
#(
  parameter int RECORDS   = RECORDS_DEF,
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [BYTE_W-1:0]    in_speed_whole,
  input  logic [BYTE_W-1:0]    in_speed_tenth,
  input  logic [TIME_W-1:0]    in_time_now,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_kind,
  output logic [SPD_W-1:0]     out_speed_out,
  output logic [SPD_W-1:0]     out_max_out,
  output logic [SPD_W-1:0]     out_min_out,
  output logic [TIME_W-1:0]    out_max_time_out,
  output logic [TIME_W-1:0]    out_min_time_out,
  output logic [DIST_W-1:0]    out_distance_mm,
  output logic [SLOT_W-1:0]    out_slot_or_count,
  output logic [LAMP_W-1:0]    out_lamp_cmd_id,
  output logic                 out_lamp_on,
  output logic                 out_last
);

  localparam int IDX_W  = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W  = $clog2(RECORDS + 1);
  localparam int PROD_W = STEP_BITS + MMPS_W;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SPEED  = 6'b000010,
    S_MUL    = 6'b000100,
    S_REPORT = 6'b001000,
    S_RD     = 6'b010000,
    S_CHK    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [LAMP_W-1:0] lamp_id_r;
  logic [MMPS_W-1:0] mm_per_step_r;

  // Running state of the recorder.
  logic [STEP_BITS-1:0] step_count_r, step_count_nxt;
  logic [SPD_W-1:0]     run_max_r, run_max_nxt;
  logic [SPD_W-1:0]     run_min_r, run_min_nxt;
  logic [TIME_W-1:0]    max_time_r, max_time_nxt;
  logic [TIME_W-1:0]    min_time_r, min_time_nxt;
  logic                 rising_r, rising_nxt;
  logic                 falling_r, falling_nxt;
  logic                 cap_pend_r, cap_pend_nxt;
  logic [CNT_W-1:0]     rec_cnt_r, rec_cnt_nxt;
  logic [SPD_W-1:0]     cap_max_r, cap_max_nxt;
  logic [SPD_W-1:0]     cap_min_r, cap_min_nxt;
  logic                 has_ne_r, has_ne_nxt;
  logic [IDX_W-1:0]     last_ne_r, last_ne_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;

  // Latched item fields and the distance product.
  logic [BYTE_W-1:0] whole_r;
  logic [BYTE_W-1:0] tenth_r;
  logic [TIME_W-1:0] now_r;
  logic [PROD_W-1:0] prod_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic              o_kind_r;
  logic [SPD_W-1:0]  o_speed_r;
  logic [SPD_W-1:0]  o_max_r;
  logic [SPD_W-1:0]  o_min_r;
  logic [TIME_W-1:0] o_max_time_r;
  logic [TIME_W-1:0] o_min_time_r;
  logic [DIST_W-1:0] o_dist_r;
  logic [SLOT_W-1:0] o_slot_r;
  logic [LAMP_W-1:0] o_lamp_id_r;
  logic              o_lamp_on_r;
  logic              o_last_r;

  logic in_acc;
  logic out_free;
  logic cap_do;
  logic run_nonempty;
  logic ld_report;
  logic ld_record;
  logic rd_en;
  logic rd_nonempty;
  logic scan_at_last;
  logic [SPD_W-1:0] speed_v;
  logic [PROD_W+DIST_W-1:0] prod_ext;
  logic [DIST_W-1:0] dist_sat;
  rec_t wr_rec;
  rec_t rd_rec;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A capture happens at acceptance when one is pending or requested, and only while
  // the store still has a free slot.
  assign cap_do = in_acc && (cap_pend_r || (in_opcode == OP_CAPTURE)) &&
                  (rec_cnt_r < CNT_W'(RECORDS));
  assign run_nonempty = (run_max_r != '0) || (run_min_r != MIN_RESET);

  assign wr_rec.max_spd  = run_max_r;
  assign wr_rec.min_spd  = run_min_r;
  assign wr_rec.max_time = max_time_r;
  assign wr_rec.min_time = min_time_r;

  // Speed in tenths from the latched frame.
  assign speed_v = SPD_W'(whole_r) * SPEED_SCALE + SPD_W'(tenth_r);

  // Distance saturates when any product bit lies above the output width.
  assign prod_ext = {{DIST_W{1'b0}}, prod_r};
  assign dist_sat = (|prod_ext[PROD_W+DIST_W-1:DIST_W]) ? '1 : prod_ext[DIST_W-1:0];

  assign rd_en        = (state_r == S_RD);
  assign rd_nonempty  = (rd_rec.max_spd != '0) || (rd_rec.min_spd != MIN_RESET);
  assign scan_at_last = (scan_idx_r == last_ne_r);
  assign ld_report    = (state_r == S_REPORT) && out_free;
  assign ld_record    = (state_r == S_CHK) && rd_nonempty && out_free;

  ser_rec_mem #(
    .RECORDS (RECORDS)
  ) u_rec_mem (
    .clk     (clk),
    .wr_en   (cap_do),
    .wr_addr (rec_cnt_r[IDX_W-1:0]),
    .wr_data (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (rd_rec)
  );

  // Next-state logic for the sequencer and the running state.
  always_comb begin
    state_nxt      = state_r;
    step_count_nxt = step_count_r;
    run_max_nxt    = run_max_r;
    run_min_nxt    = run_min_r;
    max_time_nxt   = max_time_r;
    min_time_nxt   = min_time_r;
    rising_nxt     = rising_r;
    falling_nxt    = falling_r;
    cap_pend_nxt   = cap_pend_r;
    rec_cnt_nxt    = rec_cnt_r;
    cap_max_nxt    = cap_max_r;
    cap_min_nxt    = cap_min_r;
    has_ne_nxt     = has_ne_r;
    last_ne_nxt    = last_ne_r;
    scan_idx_nxt   = scan_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cap_pend_nxt = 1'b0;
          if (cap_do) begin
            cap_max_nxt = run_max_r;
            cap_min_nxt = run_min_r;
            run_max_nxt = '0;
            run_min_nxt = MIN_RESET;
            rec_cnt_nxt = rec_cnt_r + 1'b1;
            // Track the highest slot worth listing so a readout knows its last beat.
            if (run_nonempty) begin
              has_ne_nxt  = 1'b1;
              last_ne_nxt = rec_cnt_r[IDX_W-1:0];
            end
          end
          case (in_opcode)
            OP_SPEED: begin
              state_nxt = S_SPEED;
            end
            OP_READOUT: begin
              scan_idx_nxt = '0;
              if (has_ne_nxt) begin
                state_nxt = S_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SPEED: begin
        if ((whole_r != '0) && (step_count_r != '1)) begin
          step_count_nxt = step_count_r + 1'b1;
        end
        if (speed_v != '0) begin
          cap_pend_nxt = 1'b1;
        end
        // A new maximum arms the rising flag; the first lower speed afterwards
        // stamps the time of the maximum.
        if (speed_v >= run_max_r) begin
          run_max_nxt = speed_v;
          rising_nxt  = 1'b1;
        end
        if ((speed_v < run_max_nxt) && rising_nxt) begin
          max_time_nxt = now_r;
          rising_nxt   = 1'b0;
        end
        // The minimum ignores standstill and never rises above the maximum.
        if ((speed_v < run_min_r) && (speed_v != '0)) begin
          run_min_nxt = (speed_v >= run_max_nxt) ? run_max_nxt : speed_v;
          falling_nxt = 1'b1;
        end
        if ((speed_v >= run_min_nxt) && falling_nxt) begin
          min_time_nxt = now_r;
          falling_nxt  = 1'b0;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (!rd_nonempty) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          state_nxt    = S_RD;
        end else if (out_free) begin
          if (scan_at_last) begin
            state_nxt = S_IDLE;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_report || ld_record) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and recorder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      lamp_id_r     <= '0;
      mm_per_step_r <= MMPS_RESET;
      step_count_r  <= '0;
      run_max_r     <= '0;
      run_min_r     <= MIN_RESET;
      max_time_r    <= '0;
      min_time_r    <= '0;
      rising_r      <= 1'b0;
      falling_r     <= 1'b0;
      cap_pend_r    <= 1'b0;
      rec_cnt_r     <= '0;
      cap_max_r     <= '0;
      cap_min_r     <= '0;
      has_ne_r      <= 1'b0;
      last_ne_r     <= '0;
      scan_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_count_r <= step_count_nxt;
      run_max_r    <= run_max_nxt;
      run_min_r    <= run_min_nxt;
      max_time_r   <= max_time_nxt;
      min_time_r   <= min_time_nxt;
      rising_r     <= rising_nxt;
      falling_r    <= falling_nxt;
      cap_pend_r   <= cap_pend_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      cap_max_r    <= cap_max_nxt;
      cap_min_r    <= cap_min_nxt;
      has_ne_r     <= has_ne_nxt;
      last_ne_r    <= last_ne_nxt;
      scan_idx_r   <= scan_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAMP_ID: begin
            lamp_id_r <= cfg_wdata[LAMP_W-1:0];
          end
          CFG_MM_PER_STEP: begin
            mm_per_step_r <= cfg_wdata[MMPS_W-1:0];
          end
          default: begin
            lamp_id_r <= lamp_id_r;
          end
        endcase
      end
    end
  end

  // Payload registers: latched frame fields, the product and the output beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      whole_r <= in_speed_whole;
      tenth_r <= in_speed_tenth;
      now_r   <= in_time_now;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(step_count_r) * PROD_W'(mm_per_step_r);
    end
    if (ld_report) begin
      o_kind_r     <= KIND_REPORT;
      o_speed_r    <= speed_v;
      o_max_r      <= cap_max_r;
      o_min_r      <= cap_min_r;
      o_max_time_r <= '0;
      o_min_time_r <= '0;
      o_dist_r     <= dist_sat;
      o_slot_r     <= SLOT_W'(rec_cnt_r);
      o_lamp_id_r  <= lamp_id_r;
      o_lamp_on_r  <= (speed_v != '0);
      o_last_r     <= 1'b1;
    end else if (ld_record) begin
      o_kind_r     <= KIND_RECORD;
      o_speed_r    <= '0;
      o_max_r      <= rd_rec.max_spd;
      o_min_r      <= rd_rec.min_spd;
      o_max_time_r <= rd_rec.max_time;
      o_min_time_r <= rd_rec.min_time;
      o_dist_r     <= '0;
      o_slot_r     <= SLOT_W'(scan_idx_r);
      o_lamp_id_r  <= '0;
      o_lamp_on_r  <= 1'b0;
      o_last_r     <= scan_at_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = o_kind_r;
  assign out_speed_out     = o_speed_r;
  assign out_max_out       = o_max_r;
  assign out_min_out       = o_min_r;
  assign out_max_time_out  = o_max_time_r;
  assign out_min_time_out  = o_min_time_r;
  assign out_distance_mm   = o_dist_r;
  assign out_slot_or_count = o_slot_r;
  assign out_lamp_cmd_id   = o_lamp_id_r;
  assign out_lamp_on       = o_lamp_on_r;
  assign out_last          = o_last_r;

endmodule
